[design/ktu_pkg.sv]
// Shared types and constants for the keyed table update-or-insert block.
package ktu_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_W   = 48;
    localparam int CHAN_W  = 8;
    localparam int LEVEL_W = 8;
    localparam int RIDX_W  = 6;
    localparam int PKT_W   = 32;
    localparam int ECNT_W  = 7;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    typedef enum logic {
        OP_OBSERVE = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_UPDATE
    } t_back_state;

    typedef struct packed {
        t_op                       op;
        logic [KEY_W-1:0]          key;
        logic [CHAN_W-1:0]         chan;
        logic signed [LEVEL_W-1:0] level;
        logic [RIDX_W-1:0]         idx;
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [CHAN_W-1:0]         chan;
        logic signed [LEVEL_W-1:0] level;
        logic [PKT_W-1:0]          packets;
    } t_entry;

    typedef struct packed {
        logic                      was_added;
        logic [ECNT_W-1:0]         entry_count;
        logic                      read_valid;
        logic [KEY_W-1:0]          read_key;
        logic [CHAN_W-1:0]         read_channel;
        logic signed [LEVEL_W-1:0] read_level;
        logic [PKT_W-1:0]          read_packets;
    } t_result;

endpackage

[design/ktu_front.sv]
// Input stage: accepts words and decodes them into table commands.
module ktu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [71:0]       i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_q_ready,
    output logic              o_push,
    output ktu_pkg::t_cmd     o_cmd
);

    logic          r_valid;
    logic          n_valid;
    ktu_pkg::t_cmd r_cmd;
    ktu_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_s_tready = !r_valid || i_q_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = r_valid && i_q_ready;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd       = r_cmd;
        n_valid     = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid     = 1'b1;
            n_cmd.op    = ktu_pkg::t_op'(i_s_tuser);
            n_cmd.key   = i_s_tdata[47:0];
            n_cmd.chan  = i_s_tdata[55:48];
            n_cmd.level = i_s_tdata[63:56];
            n_cmd.idx   = i_s_tdata[69:64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

[design/ktu_queue.sv]
// Short command queue between the input stage and the table engine.
module ktu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ktu_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output ktu_pkg::t_cmd o_cmd
);

    ktu_pkg::t_cmd  r_slot [ktu_pkg::QUEUE_DEPTH];
    ktu_pkg::t_qptr r_wr_ptr;
    ktu_pkg::t_qptr r_rd_ptr;
    ktu_pkg::t_qcnt r_count;

    assign o_ready = r_count < ktu_pkg::t_qcnt'(ktu_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + ktu_pkg::t_qptr'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + ktu_pkg::t_qptr'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + ktu_pkg::t_qcnt'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - ktu_pkg::t_qcnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/ktu_back.sv]
// Table engine: parallel key match, entry memory, update, append or read, result register.
module ktu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ktu_pkg::t_cmd     i_q_cmd,
    output logic              o_pop,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output ktu_pkg::t_result  o_result
);

    ktu_pkg::t_back_state r_state;
    ktu_pkg::t_back_state n_state;
    ktu_pkg::t_cmd        r_cmd;
    ktu_pkg::t_cmd        n_cmd;
    ktu_pkg::t_cnt        r_fill;
    ktu_pkg::t_cnt        n_fill;
    ktu_pkg::t_idx        r_hit_idx;
    ktu_pkg::t_idx        n_hit_idx;
    logic                 r_out_valid;
    logic                 n_out_valid;
    ktu_pkg::t_result     r_out;
    ktu_pkg::t_result     n_out;

    // Key cells: each one is compared against the incoming key in parallel.
    logic [ktu_pkg::KEY_W-1:0] r_cam [ktu_pkg::ENTRIES];
    logic [ktu_pkg::ENTRIES-1:0] r_match;
    logic [ktu_pkg::ENTRIES-1:0] n_match;
    logic                        cam_we;

    // Entry memory with a registered read port.
    ktu_pkg::t_entry r_mem [ktu_pkg::ENTRIES];
    ktu_pkg::t_entry r_rdata;
    logic            mem_re;
    ktu_pkg::t_idx   mem_raddr;
    logic            mem_we;
    ktu_pkg::t_idx   mem_waddr;
    ktu_pkg::t_entry mem_wdata;

    logic          hit;
    ktu_pkg::t_idx hit_idx;
    logic          rd_ok;

    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        for (int i = 0; i < ktu_pkg::ENTRIES; i++) begin
            n_match[ktu_pkg::t_idx'(i)] = (ktu_pkg::t_cnt'(i) < r_fill) &&
                                          (r_cam[ktu_pkg::t_idx'(i)] == i_q_cmd.key);
        end
    end

    // Keys are unique among stored entries, so at most one match bit is set.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ktu_pkg::ENTRIES; i++) begin
            hit_idx = hit_idx | (r_match[ktu_pkg::t_idx'(i)] ? ktu_pkg::t_idx'(i) : '0);
        end
        hit = |r_match;
    end

    assign rd_ok = 32'(r_cmd.idx) < 32'(r_fill);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_fill      = r_fill;
        n_hit_idx   = r_hit_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_ready;
        o_pop       = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = ktu_pkg::t_idx'(i_q_cmd.idx);
        mem_we      = 1'b0;
        mem_waddr   = ktu_pkg::t_idx'(r_fill);
        mem_wdata   = '0;
        cam_we      = 1'b0;
        case (r_state)
            ktu_pkg::ST_IDLE: begin
                if (i_q_valid && (!r_out_valid || i_m_ready)) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_cmd;
                    mem_re  = 1'b1;
                    n_state = ktu_pkg::ST_RESOLVE;
                end
            end
            ktu_pkg::ST_RESOLVE: begin
                n_out             = '0;
                n_out.entry_count = ktu_pkg::ECNT_W'(r_fill);
                if (r_cmd.op == ktu_pkg::OP_READ) begin
                    if (rd_ok) begin
                        n_out.read_valid   = 1'b1;
                        n_out.read_key     = r_rdata.key;
                        n_out.read_channel = r_rdata.chan;
                        n_out.read_level   = r_rdata.level;
                        n_out.read_packets = r_rdata.packets;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ktu_pkg::ST_IDLE;
                end else if (hit) begin
                    mem_re    = 1'b1;
                    mem_raddr = hit_idx;
                    n_hit_idx = hit_idx;
                    n_state   = ktu_pkg::ST_UPDATE;
                end else begin
                    if (r_fill < ktu_pkg::t_cnt'(ktu_pkg::ENTRIES)) begin
                        mem_we            = 1'b1;
                        mem_wdata.key     = r_cmd.key;
                        mem_wdata.chan    = r_cmd.chan;
                        mem_wdata.level   = r_cmd.level;
                        mem_wdata.packets = ktu_pkg::PKT_W'(1);
                        cam_we            = 1'b1;
                        n_fill            = r_fill + ktu_pkg::t_cnt'(1);
                        n_out.was_added   = 1'b1;
                        n_out.entry_count = ktu_pkg::ECNT_W'(n_fill);
                    end
                    n_out_valid = 1'b1;
                    n_state     = ktu_pkg::ST_IDLE;
                end
            end
            ktu_pkg::ST_UPDATE: begin
                mem_we            = 1'b1;
                mem_waddr         = r_hit_idx;
                mem_wdata.key     = r_cmd.key;
                mem_wdata.chan    = r_cmd.chan;
                mem_wdata.level   = r_cmd.level;
                mem_wdata.packets = r_rdata.packets + ktu_pkg::PKT_W'(1);
                n_out             = '0;
                n_out.entry_count = ktu_pkg::ECNT_W'(r_fill);
                n_out_valid       = 1'b1;
                n_state           = ktu_pkg::ST_IDLE;
            end
            default: begin
                n_state = ktu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ktu_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_hit_idx <= n_hit_idx;
        r_out     <= n_out;
        if (o_pop) begin
            r_match <= n_match;
        end
        if (cam_we) begin
            r_cam[ktu_pkg::t_idx'(r_fill)] <= r_cmd.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

[design/keyed_table_update_or_insert_top.sv]
// Top level of the keyed table: observe updates or appends an entry, read returns one.
// A word passes the input stage register, the queue, the engine's resolve state and the
// result register; an observe that hits also passes the update state, since the packet
// count is read from and written back to the entry memory.
// Reset clears the control state and sets the entry count to zero; stored entries are
// not cleared and are only read after they were written.
module keyed_table_update_or_insert_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // Fields from bit 0: station_key[47:0], radio_channel[55:48], signal_level[63:56],
    // read_index[69:64], zero fill[71:70].
    input  logic [71:0]   i_s_tdata,
    // action: 0 observe an access point, 1 read a stored entry by index.
    input  logic          i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // Fields from bit 0: was_added[0], entry_count[7:1], read_valid[8],
    // read_key[56:9], read_channel[64:57], read_level[72:65], read_packets[104:73],
    // zero fill[111:105].
    output logic [111:0]  o_m_tdata
);

    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;
    ktu_pkg::t_cmd    front_cmd;
    ktu_pkg::t_cmd    q_cmd;
    ktu_pkg::t_result result;

    // The input stage decodes each word into a command and hands it to the queue.
    ktu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // The queue lets new words come in while the engine works or its result waits.
    ktu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // The engine matches keys in all entries at once, then updates, appends or reads.
    ktu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_result  (result)
    );

    assign o_m_tdata = {7'b0,
                        result.read_packets,
                        result.read_level,
                        result.read_channel,
                        result.read_key,
                        result.read_valid,
                        result.entry_count,
                        result.was_added};

endmodule
